// ----- design/abq_pkg.sv -----
// ----------------------------------------------------------------------------
// abq_pkg
// Shared types, codes and double-precision compare helpers for the adaptive
// bisection quadrature controller.
// ----------------------------------------------------------------------------
package abq_pkg;

    localparam int MAX_STEPS = 64;
    localparam int IDX_W     = $clog2(MAX_STEPS);
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    localparam logic [63:0] DBL_HALF = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] DBL_DNAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] DBL_QBIT = 64'h0008_0000_0000_0000;

    localparam logic [0:0] CFG_REL = 1'b0;
    localparam logic [0:0] CFG_ABS = 1'b1;

    localparam logic OPC_START = 1'b0;
    localparam logic OPC_CONT  = 1'b1;

    localparam logic [1:0] ST_REQ  = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] FOP_ADD = 2'd0;
    localparam logic [1:0] FOP_SUB = 2'd1;
    localparam logic [1:0] FOP_MUL = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [63:0] lower;
        logic [63:0] upper;
        logic [63:0] area_a;
        logic [63:0] err_a;
        logic [63:0] area_b;
        logic [63:0] err_b;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] left_lower;
        logic [63:0] mid_point;
        logic [63:0] right_upper;
        logic [63:0] total;
        logic [6:0]  intervals_used;
    } t_out;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] area;
        logic [63:0] err;
    } t_ent;

    typedef struct packed {
        logic        go;
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } t_freq;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fresp;

    function automatic logic f_nan(input logic [63:0] x);
        return (&x[62:52]) && (|x[51:0]);
    endfunction

    function automatic logic [63:0] f_key(input logic [63:0] x);
        return x[63] ? ~x : {1'b1, x[62:0]};
    endfunction

    // IEEE less-than: false on NaN, signed zeros compare equal
    function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
        logic zz;
        zz = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        return !f_nan(a) && !f_nan(b) && !zz && (f_key(a) < f_key(b));
    endfunction

    function automatic logic f_le(input logic [63:0] a, input logic [63:0] b);
        logic zz;
        zz = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        return !f_nan(a) && !f_nan(b) && (zz || (a == b) || (f_key(a) < f_key(b)));
    endfunction

    function automatic logic [63:0] f_max(input logic [63:0] x, input logic [63:0] y);
        return f_lt(x, y) ? y : x;
    endfunction

endpackage

// ----- design/abq_fpu.sv -----
// ----------------------------------------------------------------------------
// abq_fpu
// Shared multi-cycle double-precision add, subtract and multiply unit with
// round-to-nearest-even, subnormals and NaN propagation.
// ----------------------------------------------------------------------------
module abq_fpu import abq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_freq  i_req,
    output t_fresp o_resp
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_PREP  = 3'd1;
    localparam logic [2:0] F_MUL   = 3'd2;
    localparam logic [2:0] F_LZ    = 3'd3;
    localparam logic [2:0] F_SHIFT = 3'd4;
    localparam logic [2:0] F_ROUND = 3'd5;

    logic [2:0]          r_st, n_st;
    logic [1:0]          r_op;
    logic [63:0]         r_a, r_b;
    logic [105:0]        r_w, n_w;
    logic signed [13:0]  r_r, n_r;
    logic                r_sign, n_sign;
    logic [1:0]          r_pp, n_pp;
    logic                r_left, n_left;
    logic [6:0]          r_sh, n_sh;
    logic                r_done, n_done;
    logic [63:0]         r_res, n_res;

    logic [10:0] ea, eb, eae, ebe, ebig, esml, d;
    logic [52:0] ma, mb, mbig, msml;
    logic        bsgn, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap, sbig, eff_sub;
    logic [55:0] ms56, shr, al;
    logic [56:0] sum57;
    logic [26:0] pa, pb;
    logic [53:0] prod;
    logic [105:0] term, rsh_t;
    logic [6:0]  shamt, lz;
    logic signed [13:0] lzs, rml, neg, rr;
    logic [52:0] m, mf;
    logic [53:0] m1;
    logic        g, st, up;

    function automatic logic [6:0] f_clz(input logic [105:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd106;
        found = 1'b0;
        for (int i = 105; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 7'(105 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    always_comb begin
        ea = r_a[62:52];
        eb = r_b[62:52];
        eae = (ea == 11'd0) ? 11'd1 : ea;
        ebe = (eb == 11'd0) ? 11'd1 : eb;
        ma = {|ea, r_a[51:0]};
        mb = {|eb, r_b[51:0]};
        bsgn = r_b[63] ^ (r_op == FOP_SUB);
        nan_a = f_nan(r_a);
        nan_b = f_nan(r_b);
        inf_a = (&ea) && !(|r_a[51:0]);
        inf_b = (&eb) && !(|r_b[51:0]);
        zero_a = (r_a[62:0] == 63'd0);
        zero_b = (r_b[62:0] == 63'd0);
        swap = r_a[62:0] < r_b[62:0];
        ebig = swap ? ebe : eae;
        esml = swap ? eae : ebe;
        mbig = swap ? mb : ma;
        msml = swap ? ma : mb;
        sbig = swap ? bsgn : r_a[63];
        eff_sub = r_a[63] ^ bsgn;
        d = ebig - esml;
        ms56 = {msml, 3'b000};
        shr = ms56 >> d[5:0];
        if (d >= 11'd56) begin
            al = {55'd0, |msml};
        end else begin
            al = shr | {55'd0, ((shr << d[5:0]) != ms56)};
        end
        sum57 = eff_sub ? ({1'b0, mbig, 3'b000} - {1'b0, al})
                        : ({1'b0, mbig, 3'b000} + {1'b0, al});

        pa = r_pp[1] ? {1'b0, ma[52:27]} : ma[26:0];
        pb = r_pp[0] ? {1'b0, mb[52:27]} : mb[26:0];
        prod = pa * pb;
        unique case (r_pp)
            2'd0:    shamt = 7'd0;
            2'd3:    shamt = 7'd54;
            default: shamt = 7'd27;
        endcase
        term = {52'd0, prod} << shamt;

        lz = f_clz(r_w);
        lzs = $signed(14'(lz));
        rml = r_r - lzs;
        neg = 14'sd1 - r_r;

        rsh_t = r_w >> r_sh;

        m = r_w[105:53];
        g = r_w[52];
        st = |r_w[51:0];
        up = g & (st | m[0]);
        m1 = {1'b0, m} + 54'(up);
        mf = m1[53] ? m1[53:1] : m1[52:0];
        rr = r_r + $signed({13'd0, m1[53]});
    end

    always_comb begin
        n_st = r_st;
        n_w = r_w;
        n_r = r_r;
        n_sign = r_sign;
        n_pp = r_pp;
        n_left = r_left;
        n_sh = r_sh;
        n_done = 1'b0;
        n_res = r_res;
        unique case (r_st)
            F_IDLE: begin
                if (i_req.go) begin
                    n_st = F_PREP;
                end
            end
            F_PREP: begin
                if (r_op == FOP_MUL) begin
                    n_sign = r_a[63] ^ r_b[63];
                    priority if (nan_a) begin
                        n_res = r_a | DBL_QBIT; n_done = 1'b1; n_st = F_IDLE;
                    end else if (nan_b) begin
                        n_res = r_b | DBL_QBIT; n_done = 1'b1; n_st = F_IDLE;
                    end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                        n_res = DBL_DNAN; n_done = 1'b1; n_st = F_IDLE;
                    end else if (inf_a || inf_b) begin
                        n_res = {r_a[63] ^ r_b[63], 11'h7FF, 52'd0};
                        n_done = 1'b1; n_st = F_IDLE;
                    end else begin
                        n_w = '0;
                        n_pp = 2'd0;
                        n_r = $signed(14'(eae)) + $signed(14'(ebe)) - 14'sd1022;
                        n_st = F_MUL;
                    end
                end else begin
                    priority if (nan_a) begin
                        n_res = r_a | DBL_QBIT; n_done = 1'b1; n_st = F_IDLE;
                    end else if (nan_b) begin
                        n_res = r_b | DBL_QBIT; n_done = 1'b1; n_st = F_IDLE;
                    end else if (inf_a && inf_b && eff_sub) begin
                        n_res = DBL_DNAN; n_done = 1'b1; n_st = F_IDLE;
                    end else if (inf_a) begin
                        n_res = r_a; n_done = 1'b1; n_st = F_IDLE;
                    end else if (inf_b) begin
                        n_res = {bsgn, r_b[62:0]}; n_done = 1'b1; n_st = F_IDLE;
                    end else begin
                        n_w = {sum57, 49'd0};
                        n_r = $signed(14'(ebig)) + 14'sd1;
                        n_sign = ((sum57 == 57'd0) && eff_sub) ? 1'b0 : sbig;
                        n_st = F_LZ;
                    end
                end
            end
            F_MUL: begin
                n_w = r_w + term;
                n_pp = r_pp + 2'd1;
                if (r_pp == 2'd3) begin
                    n_st = F_LZ;
                end
            end
            F_LZ: begin
                priority if (r_w == 106'd0) begin
                    n_res = {r_sign, 63'd0};
                    n_done = 1'b1;
                    n_st = F_IDLE;
                end else if (rml >= 14'sd1) begin
                    n_left = 1'b1; n_sh = lz; n_r = rml; n_st = F_SHIFT;
                end else if (r_r >= 14'sd1) begin
                    n_left = 1'b1; n_sh = 7'(r_r - 14'sd1); n_r = 14'sd1; n_st = F_SHIFT;
                end else begin
                    n_left = 1'b0;
                    n_sh = (neg > 14'sd127) ? 7'd127 : 7'(neg);
                    n_r = 14'sd1;
                    n_st = F_SHIFT;
                end
            end
            F_SHIFT: begin
                if (r_left) begin
                    n_w = r_w << r_sh;
                end else begin
                    n_w = rsh_t | {105'd0, ((rsh_t << r_sh) != r_w)};
                end
                n_st = F_ROUND;
            end
            F_ROUND: begin
                if (rr >= 14'sd2047) begin
                    n_res = {r_sign, 11'h7FF, 52'd0};
                end else begin
                    n_res = {r_sign, mf[52] ? rr[10:0] : 11'd0, mf[51:0]};
                end
                n_done = 1'b1;
                n_st = F_IDLE;
            end
            default: n_st = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_done <= n_done;
        end
        if (r_st == F_IDLE && i_req.go) begin
            r_op <= i_req.op;
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        r_w <= n_w;
        r_r <= n_r;
        r_sign <= n_sign;
        r_pp <= n_pp;
        r_left <= n_left;
        r_sh <= n_sh;
        r_res <= n_res;
    end

    assign o_resp = '{done: r_done, res: r_res};

endmodule

// ----- design/abq_seq.sv -----
// ----------------------------------------------------------------------------
// abq_seq
// Sequencer with the interval table: bisection update, worst-error scan,
// stop test, final summation and result register.
// ----------------------------------------------------------------------------
module abq_seq import abq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic [63:0] i_rel,
    input  logic [63:0] i_abs,
    output t_freq       o_freq,
    input  t_fresp      i_fresp
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_STM   = 5'd1;
    localparam logic [4:0] S_STW   = 5'd2;
    localparam logic [4:0] S_RD    = 5'd3;
    localparam logic [4:0] S_RW    = 5'd4;
    localparam logic [4:0] S_OP    = 5'd5;
    localparam logic [4:0] S_OW    = 5'd6;
    localparam logic [4:0] S_WR1   = 5'd7;
    localparam logic [4:0] S_WR2   = 5'd8;
    localparam logic [4:0] S_SCAN  = 5'd9;
    localparam logic [4:0] S_BDM   = 5'd10;
    localparam logic [4:0] S_BDW   = 5'd11;
    localparam logic [4:0] S_SMRD  = 5'd12;
    localparam logic [4:0] S_SMRW  = 5'd13;
    localparam logic [4:0] S_SMADD = 5'd14;
    localparam logic [4:0] S_SMW   = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;

    t_ent mem [MAX_STEPS];

    logic [4:0]        r_state;
    t_in               r_in;
    t_ent              r_ent, r_rdata;
    logic [CNT_W-1:0]  r_count, r_scan_i, r_si;
    logic [IDX_W-1:0]  r_worst, r_ridx;
    logic [63:0]       r_esum, r_rarea, r_tmp, r_mid, r_best, r_sum;
    logic              r_busy, r_rq, r_rv;
    logic [2:0]        r_step;
    logic [1:0]        r_stat;
    t_out              r_pend, r_out;
    logic              r_ovalid;

    logic              accept, emit_ok, swap, we;
    logic [IDX_W-1:0]  raddr, waddr;
    t_ent              wdata, ent_a, ent_b;
    logic [63:0]       bound;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign emit_ok = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign swap    = f_lt(r_in.err_a, r_in.err_b);
    assign bound   = f_max(i_abs, i_fresp.res);

    // left half and right half entries of the interval being split
    assign ent_a = '{lo: r_ent.lo, hi: r_mid, area: r_in.area_a, err: r_in.err_a};
    assign ent_b = '{lo: r_mid, hi: r_ent.hi, area: r_in.area_b, err: r_in.err_b};

    always_comb begin
        o_freq = '{go: 1'b0, op: FOP_ADD, a: r_tmp, b: DBL_HALF};
        unique case (r_state)
            S_STM: begin
                o_freq = '{go: 1'b1, op: FOP_MUL, a: i_rel, b: {1'b0, r_in.area_a[62:0]}};
            end
            S_BDM: begin
                o_freq = '{go: 1'b1, op: FOP_MUL, a: i_rel, b: {1'b0, r_rarea[62:0]}};
            end
            S_SMADD: begin
                o_freq = '{go: 1'b1, op: FOP_ADD, a: r_sum, b: r_ent.area};
            end
            S_OP: begin
                o_freq.go = 1'b1;
                unique case (r_step)
                    3'd0: o_freq = '{go: 1'b1, op: FOP_ADD, a: r_ent.lo, b: r_ent.hi};
                    3'd1: o_freq = '{go: 1'b1, op: FOP_MUL, a: r_tmp, b: DBL_HALF};
                    3'd2: o_freq = '{go: 1'b1, op: FOP_ADD, a: r_in.err_a, b: r_in.err_b};
                    3'd3: o_freq = '{go: 1'b1, op: FOP_SUB, a: r_tmp, b: r_ent.err};
                    3'd4: o_freq = '{go: 1'b1, op: FOP_ADD, a: r_esum, b: r_tmp};
                    3'd5: o_freq = '{go: 1'b1, op: FOP_ADD, a: r_in.area_a, b: r_in.area_b};
                    3'd6: o_freq = '{go: 1'b1, op: FOP_SUB, a: r_tmp, b: r_ent.area};
                    default: o_freq = '{go: 1'b1, op: FOP_ADD, a: r_rarea, b: r_tmp};
                endcase
            end
            default: o_freq.go = 1'b0;
        endcase
    end

    always_comb begin
        we = 1'b0;
        waddr = r_worst;
        wdata = ent_a;
        unique case (r_state)
            S_STM: begin
                we = 1'b1;
                waddr = '0;
                wdata = '{lo: r_in.lower, hi: r_in.upper, area: r_in.area_a, err: r_in.err_a};
            end
            S_WR1: begin
                we = 1'b1;
                wdata = swap ? ent_b : ent_a;
            end
            S_WR2: begin
                we = 1'b1;
                waddr = r_count[IDX_W-1:0];
                wdata = swap ? ent_a : ent_b;
            end
            default: we = 1'b0;
        endcase
        priority if (r_state == S_SCAN) begin
            raddr = r_scan_i[IDX_W-1:0];
        end else if (r_state == S_SMRD || r_state == S_SMRW) begin
            raddr = r_si[IDX_W-1:0];
        end else begin
            raddr = r_worst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy <= 1'b0;
            r_count <= '0;
            r_worst <= '0;
            r_esum <= '0;
            r_rarea <= '0;
            r_ovalid <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in <= i_data;
                        if (i_data.opcode == OPC_START) begin
                            r_count <= CNT_W'(1);
                            r_worst <= '0;
                            r_rarea <= i_data.area_a;
                            r_esum <= i_data.err_a;
                            r_busy <= 1'b1;
                            r_state <= S_STM;
                        end else if (r_busy && r_count != '0
                                     && r_count < CNT_W'(MAX_STEPS)) begin
                            r_rq <= 1'b0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_STM: r_state <= S_STW;
                S_STW: begin
                    if (i_fresp.done) begin
                        if (f_lt(r_in.err_a, bound)) begin
                            r_pend <= '{status: ST_CONV, left_lower: '0, mid_point: '0,
                                        right_upper: '0, total: r_in.area_a,
                                        intervals_used: 7'(r_count)};
                            r_state <= S_EMIT;
                        end else begin
                            r_rq <= 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_RW;
                S_RW: begin
                    r_ent <= r_rdata;
                    r_step <= 3'd0;
                    r_state <= S_OP;
                end
                S_OP: r_state <= S_OW;
                S_OW: begin
                    if (i_fresp.done) begin
                        unique case (r_step)
                            3'd1: r_mid <= i_fresp.res;
                            3'd4: r_esum <= i_fresp.res;
                            3'd7: r_rarea <= i_fresp.res;
                            default: r_tmp <= i_fresp.res;
                        endcase
                        priority if (r_rq && r_step == 3'd1) begin
                            r_pend <= '{status: ST_REQ, left_lower: r_ent.lo,
                                        mid_point: i_fresp.res, right_upper: r_ent.hi,
                                        total: '0, intervals_used: 7'(r_count)};
                            r_state <= S_EMIT;
                        end else if (r_step == 3'd7) begin
                            r_state <= S_WR1;
                        end else begin
                            r_step <= r_step + 3'd1;
                            r_state <= S_OP;
                        end
                    end
                end
                S_WR1: r_state <= S_WR2;
                S_WR2: begin
                    r_count <= r_count + CNT_W'(1);
                    r_scan_i <= '0;
                    r_rv <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_scan_i < r_count) begin
                        r_scan_i <= r_scan_i + CNT_W'(1);
                        r_ridx <= r_scan_i[IDX_W-1:0];
                        r_rv <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        if (r_ridx == '0) begin
                            r_best <= r_rdata.err;
                            r_worst <= '0;
                        end else if (f_lt(r_best, r_rdata.err)) begin
                            r_best <= r_rdata.err;
                            r_worst <= r_ridx;
                        end
                        if (CNT_W'(r_ridx) == r_count - CNT_W'(1)) begin
                            r_state <= S_BDM;
                        end
                    end
                end
                S_BDM: r_state <= S_BDW;
                S_BDW: begin
                    if (i_fresp.done) begin
                        r_sum <= '0;
                        r_si <= '0;
                        priority if (f_le(r_esum, bound)) begin
                            r_stat <= ST_CONV;
                            r_state <= S_SMRD;
                        end else if (r_count >= CNT_W'(MAX_STEPS)) begin
                            r_stat <= ST_FULL;
                            r_state <= S_SMRD;
                        end else begin
                            r_rq <= 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_SMRD: r_state <= S_SMRW;
                S_SMRW: begin
                    r_ent <= r_rdata;
                    r_state <= S_SMADD;
                end
                S_SMADD: r_state <= S_SMW;
                S_SMW: begin
                    if (i_fresp.done) begin
                        r_sum <= i_fresp.res;
                        if (r_si == r_count - CNT_W'(1)) begin
                            r_pend <= '{status: r_stat, left_lower: '0, mid_point: '0,
                                        right_upper: '0, total: i_fresp.res,
                                        intervals_used: 7'(r_count)};
                            r_state <= S_EMIT;
                        end else begin
                            r_si <= r_si + CNT_W'(1);
                            r_state <= S_SMRD;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_out <= r_pend;
                        r_ovalid <= 1'b1;
                        r_busy <= (r_pend.status == ST_REQ);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STEPS))
        else $error("interval count beyond table size");

    a_worst_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_busy) |-> (CNT_W'(r_worst) < r_count))
        else $error("worst index outside held intervals");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && emit_ok && r_pend.status != ST_REQ) |=> !r_busy)
        else $error("job still busy after final word");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_rv) |-> (CNT_W'(r_ridx) < r_count))
        else $error("scan read beyond held intervals");

endmodule

// ----- design/adaptive_bisection_quadrature_ctrl_top.sv -----
// ----------------------------------------------------------------------------
// adaptive_bisection_quadrature_ctrl_top
// Throughput: one word at a time; the shared FP unit and the table scan over
// its single read port (one entry a cycle) set the figure.
// Reset: synchronous active-low; tolerances, counters and handshake clear.
// ----------------------------------------------------------------------------
module adaptive_bisection_quadrature_ctrl_top import abq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_rel, r_abs;
    t_freq       freq;
    t_fresp      fresp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel <= '0;
            r_abs <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REL: r_rel <= i_cfg_data;
                CFG_ABS: r_abs <= i_cfg_data;
                default: r_abs <= r_abs;
            endcase
        end
    end

    abq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .i_rel   (r_rel),
        .i_abs   (r_abs),
        .o_freq  (freq),
        .i_fresp (fresp)
    );

    abq_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (freq),
        .o_resp  (fresp)
    );

endmodule

// ----- verif/adaptive_bisection_quadrature_ctrl_top_test.sv -----
// ----------------------------------------------------------------------------
// adaptive_bisection_quadrature_ctrl_top_test
// Self-checking bench for the bisection quadrature controller. A short
// directed table hits reset state, extremes, NaN and infinity operands, ties
// and restarts. Random jobs follow under several tolerance settings. Every
// result word is checked field by field against a double-precision predictor.
// ----------------------------------------------------------------------------
module adaptive_bisection_quadrature_ctrl_top_test;
    import abq_pkg::*;

    localparam int DRAIN      = 900;
    localparam int HOLD_LEN   = 400;
    localparam int WDOG_LIMIT = 20000;
    localparam int RAND_ITEMS = 1330;
    localparam logic [63:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_in  w;
        bit   typed;
        t_out r;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    adaptive_bisection_quadrature_ctrl_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [63:0] rel_v, abs_v;
    real         lo_t [MAX_STEPS];
    real         hi_t [MAX_STEPS];
    real         ar_t [MAX_STEPS];
    real         er_t [MAX_STEPS];
    real         run_area, err_sum;
    int          n_held, worst;
    bit          job_open;

    t_out        result_q [$];
    int          errors, words_in, words_out, n_conv, n_full;
    bit          no_idle, hold_go, hold_done;
    int          hold_left, quiet_cycles;
    dir_row_t    dir_tab [$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic real tol_bound(input real area);
        real at, r;
        at = $bitstoreal(abs_v);
        r  = $bitstoreal(rel_v) * $bitstoreal($realtobits(area) & ABS_MASK);
        return (at < r) ? r : at;
    endfunction

    function automatic real held_sum();
        real s;
        s = 0.0;
        for (int i = 0; i < n_held && i < MAX_STEPS; i++) s = s + ar_t[i];
        return s;
    endfunction

    function automatic t_out bisect_req();
        t_out y;
        y = '0;
        y.status         = ST_REQ;
        y.left_lower     = $realtobits(lo_t[worst]);
        y.mid_point      = $realtobits((lo_t[worst] + hi_t[worst]) * 0.5);
        y.right_upper    = $realtobits(hi_t[worst]);
        y.intervals_used = n_held[6:0];
        return y;
    endfunction

    function automatic t_out job_done(input logic [1:0] st, input logic [63:0] tot);
        t_out y;
        y = '0;
        job_open         = 1'b0;
        y.status         = st;
        y.total          = tot;
        y.intervals_used = n_held[6:0];
        return y;
    endfunction

    function automatic bit predict_bisection(input t_in x, output t_out y);
        real a, e, lo, hi, mid, a1, e1, a2, e2, best, dlt;
        int  w, slot;
        y = '0;
        if (x.opcode == OPC_START) begin
            a = $bitstoreal(x.area_a);
            e = $bitstoreal(x.err_a);
            lo_t[0] = $bitstoreal(x.lower);
            hi_t[0] = $bitstoreal(x.upper);
            ar_t[0] = a;
            er_t[0] = e;
            n_held = 1; worst = 0; run_area = a; err_sum = e; job_open = 1'b1;
            if (e < tol_bound(a)) begin
                y = job_done(ST_CONV, x.area_a);
                n_conv++;
            end else y = bisect_req();
            return 1'b1;
        end
        if (!job_open || n_held == 0 || n_held >= MAX_STEPS) return 1'b0;
        w = worst; slot = n_held;
        lo = lo_t[w]; hi = hi_t[w]; mid = (lo + hi) * 0.5;
        a1 = $bitstoreal(x.area_a); e1 = $bitstoreal(x.err_a);
        a2 = $bitstoreal(x.area_b); e2 = $bitstoreal(x.err_b);
        dlt = (e1 + e2) - er_t[w];
        err_sum = err_sum + dlt;
        dlt = (a1 + a2) - ar_t[w];
        run_area = run_area + dlt;
        if (e2 > e1) begin
            lo_t[w] = mid; hi_t[w] = hi; ar_t[w] = a2; er_t[w] = e2;
            lo_t[slot] = lo; hi_t[slot] = mid; ar_t[slot] = a1; er_t[slot] = e1;
        end else begin
            hi_t[w] = mid; ar_t[w] = a1; er_t[w] = e1;
            lo_t[slot] = mid; hi_t[slot] = hi; ar_t[slot] = a2; er_t[slot] = e2;
        end
        n_held = slot + 1;
        worst = 0;
        best = er_t[0];
        for (int i = 1; i < n_held; i++) begin
            if (best < er_t[i]) begin
                best = er_t[i];
                worst = i;
            end
        end
        if (err_sum <= tol_bound(run_area)) begin
            y = job_done(ST_CONV, $realtobits(held_sum()));
            n_conv++;
        end else if (n_held >= MAX_STEPS) begin
            y = job_done(ST_FULL, $realtobits(held_sum()));
            n_full++;
        end else y = bisect_req();
        return 1'b1;
    endfunction

    task automatic report_err(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        $display("MISMATCH word %0d %s: got %h want %h", words_out, what, got, want);
        errors++;
    endtask

    // result side
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                report_err("unexpected word", o_data.total, '0);
            end else begin
                want = result_q.pop_front();
                if (o_data.status != want.status)
                    report_err("status", 64'(o_data.status), 64'(want.status));
                if (o_data.left_lower != want.left_lower)
                    report_err("left_lower", o_data.left_lower, want.left_lower);
                if (o_data.mid_point != want.mid_point)
                    report_err("mid_point", o_data.mid_point, want.mid_point);
                if (o_data.right_upper != want.right_upper)
                    report_err("right_upper", o_data.right_upper, want.right_upper);
                if (o_data.total != want.total)
                    report_err("total", o_data.total, want.total);
                if (o_data.intervals_used != want.intervals_used)
                    report_err("intervals_used", 64'(o_data.intervals_used),
                               64'(want.intervals_used));
            end
            words_out++;
        end
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else begin
            i_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input t_in w, input bit typed, input t_out r);
        t_out y;
        bit   has;
        if (!no_idle && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        words_in++;
        has = predict_bisection(w, y);
        if (typed) y = r;
        if (has || typed) result_q.push_back(y);
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_tol(input logic [0:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_REL) rel_v = val;
        else abs_v = val;
    endtask

    function automatic t_in mk_word(input logic op, input logic [63:0] lo,
                                    input logic [63:0] hi, input logic [63:0] a,
                                    input logic [63:0] e, input logic [63:0] ab,
                                    input logic [63:0] eb);
        t_in w;
        w.opcode = op; w.lower = lo; w.upper = hi;
        w.area_a = a; w.err_a = e; w.area_b = ab; w.err_b = eb;
        return w;
    endfunction

    function automatic logic [63:0] rnd_field(input bit is_err);
        real m;
        m = real'($urandom_range(1, 100000)) / 1024.0;
        case ($urandom_range(0, 24))
            0: return {$urandom, $urandom};
            1: return '0;
            2: return 64'h7FF0_0000_0000_0000;
            3: return $realtobits(-m);
            default: return $realtobits(is_err ? m * 1.0e-4 : m);
        endcase
    endfunction

    function automatic t_in rnd_word(input bit start);
        real lo, wd;
        t_in w;
        lo = real'($urandom_range(0, 2000)) / 16.0 - 60.0;
        wd = real'($urandom_range(1, 4000)) / 32.0;
        w = mk_word(start ? OPC_START : OPC_CONT, $realtobits(lo), $realtobits(lo + wd),
                    rnd_field(0), rnd_field(1), rnd_field(0), rnd_field(1));
        if ($urandom_range(0, 19) == 0) begin
            w.lower = {$urandom, $urandom};
            w.upper = {$urandom, $urandom};
        end
        return w;
    endfunction

    function automatic t_out mk_res(input logic [1:0] st, input logic [63:0] ll,
                                    input logic [63:0] md, input logic [63:0] ru,
                                    input logic [63:0] tot, input logic [6:0] n);
        t_out y;
        y.status = st; y.left_lower = ll; y.mid_point = md;
        y.right_upper = ru; y.total = tot; y.intervals_used = n;
        return y;
    endfunction

    task automatic push_row(input t_in w, input bit typed, input t_out r);
        dir_row_t row;
        row.w = w; row.typed = typed; row.r = r;
        dir_tab.push_back(row);
    endtask

    initial begin
        logic [63:0] rel_set [5];
        logic [63:0] abs_set [5];
        int          sent;
        t_in         w;
        rel_v = '0; abs_v = '0;
        run_area = 0.0; err_sum = 0.0; n_held = 0; worst = 0; job_open = 1'b0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            lo_t[i] = 0.0; hi_t[i] = 0.0; ar_t[i] = 0.0; er_t[i] = 0.0;
        end
        errors = 0; words_in = 0; words_out = 0; n_conv = 0; n_full = 0;
        no_idle = 1'b0; hold_go = 1'b0; hold_done = 1'b0; hold_left = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0; i_ready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_REL; i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, tolerances at reset value zero
        push_row(mk_word(OPC_CONT, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        push_row(mk_word(OPC_START, '0, 64'h4000_0000_0000_0000,
                         64'h3FF0_0000_0000_0000, '0, '1, '1), 1'b1,
                 mk_res(ST_REQ, '0, 64'h3FF0_0000_0000_0000,
                        64'h4000_0000_0000_0000, '0, 7'd1));
        push_row(mk_word(OPC_CONT, '1, '1, 64'h3FE0_0000_0000_0000, '0,
                         64'h3FE0_0000_0000_0000, '0), 1'b1,
                 mk_res(ST_CONV, '0, '0, '0, 64'h3FF0_0000_0000_0000, 7'd2));
        push_row(mk_word(OPC_START, 64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                         64'h4008_0000_0000_0000, 64'hBFF0_0000_0000_0000, '0, '0), 1'b1,
                 mk_res(ST_CONV, '0, '0, '0, 64'h4008_0000_0000_0000, 7'd1));
        push_row(mk_word(OPC_CONT, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        push_row(mk_word(OPC_START, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        push_row(mk_word(OPC_CONT, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        push_row(mk_word(OPC_START, '0, '0, '0, 64'h7FF0_0000_0000_0000, '0, '0),
                 1'b0, '0);
        push_row(mk_word(OPC_CONT, '0, '0, 64'h7FEF_FFFF_FFFF_FFFF, '0,
                         64'hFFEF_FFFF_FFFF_FFFF, '0), 1'b0, '0);
        push_row(mk_word(OPC_START, '0, 64'h7FEF_FFFF_FFFF_FFFF,
                         64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, '0, '0),
                 1'b0, '0);
        push_row(mk_word(OPC_CONT, '0, '0, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                         64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000), 1'b0, '0);
        push_row(mk_word(OPC_CONT, '0, '0, 64'h3FF0_0000_0000_0000, 64'h3FF8_0000_0000_0000,
                         64'h8000_0000_0000_0000, 64'h3FF8_0000_0000_0000), 1'b0, '0);
        push_row(mk_word(OPC_START, 64'hC059_0000_0000_0000, 64'h4059_0000_0000_0000,
                         64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, '0, '0),
                 1'b0, '0);
        foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);
        drain_all();

        rel_set = '{64'h3F50_624D_D2F1_A9FC, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                    64'h3F84_7AE1_47AE_147B, 64'h7FEF_FFFF_FFFF_FFFF};
        abs_set = '{64'h3EB0_C6F7_A0B5_ED8D, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                    64'h3FB9_9999_9999_999A, 64'h0000_0000_0000_0001};
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_tol(CFG_REL, rel_set[ph]);
            write_tol(CFG_ABS, abs_set[ph]);
            no_idle = (ph == 2);
            for (int k = 0; k < RAND_ITEMS / 5; k++) begin
                if (ph == 1 && k == 20) hold_go = 1'b1;
                if (job_open ? ($urandom_range(0, 99) < 94) : ($urandom_range(0, 99) < 5))
                    w = rnd_word(1'b0);
                else w = rnd_word(1'b1);
                send_word(w, 1'b0, '0);
                sent++;
            end
            drain_all();
        end

        $display("Covered %0d input words, %0d result words checked", words_in, words_out);
        $display("Jobs converged %0d, table full %0d, over 5 tolerance settings",
                 n_conv, n_full);
        if (errors == 0 && result_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
